>>> src/sau_pkg.sv
// Shared widths, codes and reset values for the servo angle pulse unit.
`default_nettype none

package sau_pkg;

    localparam int PULSE_W = 22;
    localparam int DEG_W   = 9;
    localparam int ANG_W   = 15;
    localparam int LOG_W   = 16;
    localparam int CFG_W   = 22;
    localparam int IDX_W   = 3;

    // divider operands: |num| < 2^37, den = 64 * degree span < 2^15
    localparam int NUM_W   = 37;
    localparam int DEN_W   = 15;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

    localparam logic [IDX_W-1:0] CFG_PULSE_MIN = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PULSE_MAX = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RATED_MIN = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RATED_MAX = 3'd3;
    localparam logic [IDX_W-1:0] CFG_UPPER     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_LOWER     = 3'd5;
    localparam logic [IDX_W-1:0] CFG_OFFSET    = 3'd6;

    localparam logic [PULSE_W-1:0] RST_PULSE_MIN = 22'd500000;
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX = 22'd2500000;
    localparam logic [DEG_W-1:0]   RST_RATED_MIN = 9'd0;
    localparam logic [DEG_W-1:0]   RST_RATED_MAX = 9'd180;
    localparam logic [ANG_W-1:0]   RST_UPPER     = 15'd11520;
    localparam logic [ANG_W-1:0]   RST_LOWER     = 15'd0;
    localparam logic [ANG_W-1:0]   RST_OFFSET    = 15'd0;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CLAMP_HI = 2'd1;
    localparam logic [1:0] STATUS_CLAMP_LO = 2'd2;
    localparam logic [1:0] STATUS_BAD_DIR  = 2'd3;

    localparam logic REQ_SET    = 1'b0;
    localparam logic REQ_ROTATE = 1'b1;

    localparam logic [1:0] DIR_POS = 2'b01;
    localparam logic [1:0] DIR_NEG = 2'b11;

endpackage

`default_nettype wire

>>> src/sau_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module sau_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sau_pkg::NUM_W-1:0]   dividend,
    input  wire logic [sau_pkg::DEN_W-1:0]   divisor,
    output logic                             done,
    output logic [sau_pkg::NUM_W-1:0]        quotient,
    output logic                             rem_nonzero
);
    import sau_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]    shift_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;

    logic [DEN_W:0]      trial;
    logic                fits;
    logic [DEN_W-1:0]    rem_next;

    always_comb begin
        trial    = {rem_reg, shift_reg[NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            den_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[NUM_W-2:0], fits};
            rem_reg   <= rem_next;
        end
    end

    assign done        = done_reg;
    assign quotient    = shift_reg;
    assign rem_nonzero = |rem_reg;

endmodule

`default_nettype wire

>>> src/servo_angle_pulse_unit_top.sv
// Servo angle to PWM pulse unit: command sequencer, state and output register.
//
// Input transaction (s_valid/s_ready): an absolute logical angle (s_req_type 0) or a
// relative rotation with direction +1/-1 (s_req_type 1), angles in 1/64 degree.
// Output transaction (m_valid/m_ready): pulse width in ns, status, and the logical
// and physical angles after the command.
// Configuration: cfg_we writes cfg_wdata into register cfg_index;
// writing the offset also clears the logical angle. Write only while idle.
// One command is worked on at a time; s_ready is high only in the idle state.
// A normal command goes through operand prep, multiply, divider start, the serial
// divider that forms the 37-bit slope quotient, a wait state that sees it finish, and
// the final step. A bad direction or an empty rated range skips the divider. A new
// command is accepted only after the last one has left the final step.
// The result sits in an output register, so the next command is accepted while it
// waits; a stalled receiver holds the final step until the register frees up.
// Reset (aresetn, synchronous, active low) restores register defaults, clears the
// logical angle and drops m_valid.
`default_nettype none

module servo_angle_pulse_unit_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [sau_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [sau_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic signed [15:0]            s_angle_value,
    input  wire logic signed [1:0]             s_rotate_dir,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sau_pkg::PULSE_W-1:0]        m_pulse_ns,
    output logic [1:0]                         m_status,
    output logic signed [sau_pkg::LOG_W-1:0]   m_logical_now,
    output logic [sau_pkg::ANG_W-1:0]          m_physical_now
);
    import sau_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [PULSE_W-1:0] pulse_min_reg;
    logic [PULSE_W-1:0] pulse_max_reg;
    logic [DEG_W-1:0]   rated_min_reg;
    logic [DEG_W-1:0]   rated_max_reg;
    logic [ANG_W-1:0]   upper_reg;
    logic [ANG_W-1:0]   lower_reg;
    logic [ANG_W-1:0]   offset_reg;
    logic signed [LOG_W-1:0] logical_reg;

    // per-command work registers
    logic [ANG_W-1:0]   phys_reg;
    logic [1:0]         status_reg;
    logic               bad_reg;
    logic               empty_reg;
    logic [21:0]        pmag_reg;
    logic [14:0]        amag_reg;
    logic               neg_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [NUM_W-1:0]   num_reg;

    // output register
    logic               m_valid_reg;
    logic [PULSE_W-1:0] pulse_out_reg;
    logic [1:0]         status_out_reg;
    logic signed [LOG_W-1:0] logical_out_reg;
    logic [ANG_W-1:0]   phys_out_reg;

    logic               in_fire;
    logic               out_free;

    // command front end
    logic               dir_ok;
    logic               bad_cmd;
    logic signed [17:0] target;
    logic signed [18:0] phys_raw;
    logic [ANG_W-1:0]   phys_clamp;
    logic [1:0]         status_calc;
    logic signed [16:0] logical_calc;

    // operand prep
    logic [ANG_W-1:0]   a_clamp;
    logic signed [15:0] adiff;
    logic signed [22:0] pdiff;
    logic [21:0]        pmag;
    logic [14:0]        amag;
    logic [DEG_W-1:0]   span;

    // divider
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic               div_rem_nz;

    // final pulse
    logic signed [NUM_W:0]   q_floor;
    logic signed [NUM_W+1:0] pulse_sum;
    logic [PULSE_W-1:0]      pulse_sat;
    logic [PULSE_W-1:0]      pulse_final;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        dir_ok  = (s_rotate_dir == DIR_POS) || (s_rotate_dir == DIR_NEG);
        bad_cmd = (s_req_type == REQ_ROTATE) && !dir_ok;
        if (s_req_type == REQ_SET) begin
            target = 18'(s_angle_value);
        end else if (s_rotate_dir == DIR_POS) begin
            target = 18'(logical_reg) + 18'(s_angle_value);
        end else begin
            target = 18'(logical_reg) - 18'(s_angle_value);
        end
        phys_raw = 19'(target) + $signed({4'b0, offset_reg});
        if (phys_raw > $signed({4'b0, upper_reg})) begin
            phys_clamp  = upper_reg;
            status_calc = STATUS_CLAMP_HI;
        end else if (phys_raw < $signed({4'b0, lower_reg})) begin
            phys_clamp  = lower_reg;
            status_calc = STATUS_CLAMP_LO;
        end else begin
            phys_clamp  = phys_raw[ANG_W-1:0];
            status_calc = STATUS_OK;
        end
        logical_calc = $signed({2'b0, phys_clamp}) - $signed({2'b0, offset_reg});
    end

    // the pulse angle is clamped again, lower limit first
    always_comb begin
        if (phys_reg < lower_reg) begin
            a_clamp = lower_reg;
        end else if (phys_reg > upper_reg) begin
            a_clamp = upper_reg;
        end else begin
            a_clamp = phys_reg;
        end
        adiff = $signed({1'b0, a_clamp}) - $signed({1'b0, rated_min_reg, 6'b0});
        pdiff = $signed({1'b0, pulse_max_reg}) - $signed({1'b0, pulse_min_reg});
        amag  = adiff[15] ? 15'(-adiff) : adiff[14:0];
        pmag  = pdiff[22] ? 22'(-pdiff) : pdiff[21:0];
        span  = rated_max_reg - rated_min_reg;
    end

    assign div_start = (state_reg == ST_DIV_GO);

    sau_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .dividend    (num_reg),
        .divisor     (den_reg),
        .done        (div_done),
        .quotient    (div_quot),
        .rem_nonzero (div_rem_nz)
    );

    // floor toward minus infinity: -Q when exact, -Q-1 (= ~Q) otherwise
    always_comb begin
        if (!neg_reg) begin
            q_floor = $signed({1'b0, div_quot});
        end else if (div_rem_nz) begin
            q_floor = ~$signed({1'b0, div_quot});
        end else begin
            q_floor = -$signed({1'b0, div_quot});
        end
        pulse_sum = $signed({{(NUM_W+1-PULSE_W){1'b0}}, pulse_min_reg}) + (NUM_W+2)'(q_floor);
        if (pulse_sum[NUM_W+1]) begin
            pulse_sat = '0;
        end else if (|pulse_sum[NUM_W:PULSE_W]) begin
            pulse_sat = PULSE_MAX;
        end else begin
            pulse_sat = pulse_sum[PULSE_W-1:0];
        end
        if (bad_reg) begin
            pulse_final = '0;
        end else if (empty_reg) begin
            pulse_final = pulse_min_reg;
        end else begin
            pulse_final = pulse_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            pulse_min_reg <= RST_PULSE_MIN;
            pulse_max_reg <= RST_PULSE_MAX;
            rated_min_reg <= RST_RATED_MIN;
            rated_max_reg <= RST_RATED_MAX;
            upper_reg     <= RST_UPPER;
            lower_reg     <= RST_LOWER;
            offset_reg    <= RST_OFFSET;
            logical_reg   <= '0;
        end else begin
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PULSE_MIN: pulse_min_reg <= cfg_wdata[PULSE_W-1:0];
                    CFG_PULSE_MAX: pulse_max_reg <= cfg_wdata[PULSE_W-1:0];
                    CFG_RATED_MIN: rated_min_reg <= cfg_wdata[DEG_W-1:0];
                    CFG_RATED_MAX: rated_max_reg <= cfg_wdata[DEG_W-1:0];
                    CFG_UPPER:     upper_reg     <= cfg_wdata[ANG_W-1:0];
                    CFG_LOWER:     lower_reg     <= cfg_wdata[ANG_W-1:0];
                    CFG_OFFSET: begin
                        offset_reg  <= cfg_wdata[ANG_W-1:0];
                        logical_reg <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        bad_reg    <= bad_cmd;
                        phys_reg   <= phys_clamp;
                        status_reg <= status_calc;
                        if (!bad_cmd) begin
                            logical_reg <= logical_calc[LOG_W-1:0];
                        end
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    amag_reg  <= amag;
                    pmag_reg  <= pmag;
                    neg_reg   <= adiff[15] ^ pdiff[22];
                    den_reg   <= {span, 6'b0};
                    empty_reg <= (rated_max_reg <= rated_min_reg);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    num_reg <= NUM_W'(pmag_reg * amag_reg);
                    if (bad_reg || empty_reg) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        pulse_out_reg   <= pulse_final;
                        status_out_reg  <= bad_reg ? STATUS_BAD_DIR : status_reg;
                        logical_out_reg <= logical_reg;
                        phys_out_reg    <= bad_reg ? '0 : phys_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_pulse_ns     = pulse_out_reg;
    assign m_status       = status_out_reg;
    assign m_logical_now  = logical_out_reg;
    assign m_physical_now = phys_out_reg;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the servo angle pulse unit: predictor, scoreboard, stimulus.
module tb_top;
    import sau_pkg::*;

    localparam int PHASE_ITEMS    = 107;
    localparam int LAST_PHASE     = 13;
    localparam int SETTLE_CYCLES  = 50;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    // rotate directions that the block must reject
    localparam logic [1:0] DIR_ZERO      = 2'b00;
    localparam logic [1:0] DIR_MINUS_TWO = 2'b10;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [PULSE_W-1:0]       pulse;
        logic [1:0]               status;
        logic signed [LOG_W-1:0]  logical;
        logic [ANG_W-1:0]         physical;
    } servo_result_t;

    class pulse_scoreboard;
        int pulse_min_ns, pulse_max_ns, rated_min, rated_max;
        int upper_lim, lower_lim, offset;
        logic signed [LOG_W-1:0] cur_logical;
        servo_result_t expected_pulses[$];
        int mismatches;
        int results_checked;

        function new();
            pulse_min_ns  = int'(RST_PULSE_MIN);
            pulse_max_ns  = int'(RST_PULSE_MAX);
            rated_min     = int'(RST_RATED_MIN);
            rated_max     = int'(RST_RATED_MAX);
            upper_lim     = int'(RST_UPPER);
            lower_lim     = int'(RST_LOWER);
            offset        = int'(RST_OFFSET);
            cur_logical   = '0;
            mismatches    = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PULSE_MIN: pulse_min_ns = int'(data[PULSE_W-1:0]);
                CFG_PULSE_MAX: pulse_max_ns = int'(data[PULSE_W-1:0]);
                CFG_RATED_MIN: rated_min    = int'(data[DEG_W-1:0]);
                CFG_RATED_MAX: rated_max    = int'(data[DEG_W-1:0]);
                CFG_UPPER:     upper_lim    = int'(data[ANG_W-1:0]);
                CFG_LOWER:     lower_lim    = int'(data[ANG_W-1:0]);
                CFG_OFFSET: begin
                    offset      = int'(data[ANG_W-1:0]);
                    cur_logical = '0;
                end
                default: ;
            endcase
        endfunction

        function longint pulse_for_angle(int phys);
            int     ang;
            longint num, den, quo, p;
            ang = phys;
            if (ang < lower_lim)
                ang = lower_lim;
            else if (ang > upper_lim)
                ang = upper_lim;
            if (rated_max <= rated_min)
                return longint'(pulse_min_ns);
            den = longint'(rated_max - rated_min) * 64;
            num = longint'(pulse_max_ns - pulse_min_ns) * longint'(ang - rated_min * 64);
            quo = num / den;
            // round toward minus infinity
            if (num % den != 0 && num < 0)
                quo = quo - 1;
            p = longint'(pulse_min_ns) + quo;
            if (p < 0)
                p = 0;
            if (p > longint'(PULSE_MAX))
                p = longint'(PULSE_MAX);
            return p;
        endfunction

        function void note_command(logic req, logic signed [15:0] value,
                                   logic signed [1:0] dir);
            servo_result_t r;
            int amount, cur, target, phys;
            longint p;
            amount = value;
            cur    = cur_logical;
            if (req == REQ_ROTATE && dir != DIR_POS && dir != DIR_NEG) begin
                r.pulse    = '0;
                r.status   = STATUS_BAD_DIR;
                r.logical  = cur_logical;
                r.physical = '0;
            end else begin
                if (req == REQ_SET)
                    target = amount;
                else if (dir == DIR_POS)
                    target = cur + amount;
                else
                    target = cur - amount;
                phys     = target + offset;
                r.status = STATUS_OK;
                // upper limit wins when the limits are crossed
                if (phys > upper_lim) begin
                    phys     = upper_lim;
                    r.status = STATUS_CLAMP_HI;
                end else if (phys < lower_lim) begin
                    phys     = lower_lim;
                    r.status = STATUS_CLAMP_LO;
                end
                cur_logical = LOG_W'(phys - offset);
                p          = pulse_for_angle(phys);
                r.pulse    = p[PULSE_W-1:0];
                r.logical  = cur_logical;
                r.physical = phys[ANG_W-1:0];
            end
            expected_pulses.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR: %s", what);
            mismatches++;
        endtask

        task check_result(logic [PULSE_W-1:0] pulse, logic [1:0] status,
                          logic signed [LOG_W-1:0] logical,
                          logic [ANG_W-1:0] physical);
            servo_result_t want;
            if (expected_pulses.size() == 0) begin
                report($sformatf("result with no command pending (pulse %0d status %0d)",
                                 pulse, status));
                return;
            end
            want = expected_pulses.pop_front();
            results_checked++;
            if (pulse !== want.pulse)
                report($sformatf("result %0d pulse_ns %0d, want %0d",
                                 results_checked, pulse, want.pulse));
            if (status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 results_checked, status, want.status));
            if (logical !== want.logical)
                report($sformatf("result %0d logical_now %0d, want %0d",
                                 results_checked, logical, want.logical));
            if (physical !== want.physical)
                report($sformatf("result %0d physical_now %0d, want %0d",
                                 results_checked, physical, want.physical));
        endtask

        function int pending();
            return expected_pulses.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [IDX_W-1:0]           cfg_index;
    logic [CFG_W-1:0]           cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_req_type;
    logic signed [15:0]         s_angle_value;
    logic signed [1:0]          s_rotate_dir;
    logic                       m_valid;
    logic                       m_ready;
    logic [PULSE_W-1:0]         m_pulse_ns;
    logic [1:0]                 m_status;
    logic signed [LOG_W-1:0]    m_logical_now;
    logic [ANG_W-1:0]           m_physical_now;

    pulse_scoreboard  sb;
    logic [CFG_W-1:0] cfg_val [0:6];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    bit               hold_req = 1'b0;
    int               items_sent = 0;

    servo_angle_pulse_unit_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_angle_value  (s_angle_value),
        .s_rotate_dir   (s_rotate_dir),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pulse_ns     (m_pulse_ns),
        .m_status       (m_status),
        .m_logical_now  (m_logical_now),
        .m_physical_now (m_physical_now)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // outputs are stable at the falling edge; a transaction there completes at the next rise
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_pulse_ns, m_status, m_logical_now, m_physical_now);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction in %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_cmd(input logic req, input logic signed [15:0] value,
                            input logic signed [1:0] dir);
        bit taken;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_angle_value <= value;
        s_rotate_dir  <= dir;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            if (taken) begin
                sb.note_command(req, value, dir);
                items_sent++;
            end
            @(posedge aclk);
        end
    endtask

    task automatic send_random_cmd();
        logic              req;
        logic signed [1:0] dir;
        int                v;
        req = ($urandom_range(99) < 40) ? REQ_SET : REQ_ROTATE;
        case ($urandom_range(9))
            0: v = $urandom_range(65535) - 32768;
            1: begin
                case ($urandom_range(4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -23040;
                    3: v = 23040;
                    default: v = 0;
                endcase
            end
            2, 3: v = $urandom_range(2560) - 1280;
            default: v = $urandom_range(46080) - 23040;
        endcase
        if (req == REQ_SET)
            dir = 2'($urandom);
        else if ($urandom_range(99) < 85)
            dir = $urandom_range(1) ? DIR_POS : DIR_NEG;
        else
            dir = $urandom_range(1) ? DIR_ZERO : DIR_MINUS_TWO;
        send_cmd(req, v[15:0], dir);
    endtask

    // wait for every result, then give the block time to go idle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input bit with_offset);
        for (int i = int'(CFG_PULSE_MIN); i <= int'(CFG_OFFSET); i++) begin
            if (IDX_W'(i) != CFG_OFFSET || with_offset) begin
                cfg_we    <= 1'b1;
                cfg_index <= IDX_W'(i);
                cfg_wdata <= cfg_val[i];
                sb.write_reg(IDX_W'(i), cfg_val[i]);
                @(posedge aclk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    function automatic void set_regs(int pmin, int pmax, int rmin, int rmax,
                                     int upper, int lower, int offs);
        cfg_val[CFG_PULSE_MIN] = CFG_W'(pmin);
        cfg_val[CFG_PULSE_MAX] = CFG_W'(pmax);
        cfg_val[CFG_RATED_MIN] = CFG_W'(rmin);
        cfg_val[CFG_RATED_MAX] = CFG_W'(rmax);
        cfg_val[CFG_UPPER]     = CFG_W'(upper);
        cfg_val[CFG_LOWER]     = CFG_W'(lower);
        cfg_val[CFG_OFFSET]    = CFG_W'(offs);
    endfunction

    // mostly in the rated range, now and then any value the register holds
    function automatic logic [CFG_W-1:0] pick_reg(int lo, int hi, int w);
        if ($urandom_range(5) == 0)
            return CFG_W'($urandom & ((1 << w) - 1));
        return CFG_W'($urandom_range(hi, lo));
    endfunction

    function automatic void set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 87; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endfunction

    initial begin
        bit with_offset;
        sb            = new();
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PULSE_MIN;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_req_type    = REQ_SET;
        s_angle_value = '0;
        s_rotate_dir  = DIR_POS;
        m_ready       = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed commands at reset settings
        set_idling(IDLE_NONE);
        send_cmd(REQ_SET, 16'sd0, DIR_POS);
        send_cmd(REQ_SET, 16'sd11520, DIR_POS);
        send_cmd(REQ_SET, 16'sd11521, DIR_NEG);
        send_cmd(REQ_SET, -16'sd1, DIR_POS);
        send_cmd(REQ_SET, 16'sd23040, DIR_POS);
        send_cmd(REQ_SET, -16'sd23040, DIR_POS);
        send_cmd(REQ_SET, 16'sh7fff, DIR_POS);
        send_cmd(REQ_SET, 16'sh8000, DIR_POS);
        send_cmd(REQ_SET, 16'sd5760, DIR_MINUS_TWO);
        send_cmd(REQ_SET, 16'sd100, DIR_ZERO);
        send_cmd(REQ_ROTATE, 16'sd640, DIR_POS);
        send_cmd(REQ_ROTATE, 16'sd1280, DIR_NEG);
        send_cmd(REQ_ROTATE, 16'sd0, DIR_POS);
        send_cmd(REQ_ROTATE, 16'sd5, DIR_ZERO);
        send_cmd(REQ_ROTATE, 16'sd5, DIR_MINUS_TWO);
        send_cmd(REQ_ROTATE, 16'sh7fff, DIR_POS);
        send_cmd(REQ_ROTATE, 16'sh8000, DIR_NEG);
        send_cmd(REQ_ROTATE, 16'sh8000, DIR_POS);
        send_cmd(REQ_ROTATE, 16'sh7fff, DIR_NEG);

        for (int ph = 1; ph <= LAST_PHASE; ph++) begin
            drain();
            with_offset = 1'b1;
            case (ph)
                1: set_regs(500000, 2500000, 0, 360, 23040, 0, 11520);
                2: begin  // falling pulse slope, logical angle carried over
                    set_regs(2500000, 500000, 90, 270, 20000, 3000, 0);
                    with_offset = 1'b0;
                end
                3: set_regs(1000000, 2000000, 0, 180, 5000, 15000, 5000); // crossed limits
                4: begin  // empty rated range
                    set_regs(600000, 2400000, 200, 100, 23040, 0, 0);
                    with_offset = 1'b0;
                end
                5: set_regs(0, 4194303, 359, 360, 32767, 0, 32767);  // saturates both ways
                6: begin
                    set_regs(4194303, 0, 0, 511, 32767, 0, 0);
                    with_offset = 1'b0;
                end
                7: set_regs(500000, 500001, 359, 359, 0, 0, 0);
                LAST_PHASE: set_regs(int'(RST_PULSE_MIN), int'(RST_PULSE_MAX),
                                     int'(RST_RATED_MIN), int'(RST_RATED_MAX),
                                     int'(RST_UPPER), int'(RST_LOWER), int'(RST_OFFSET));
                default: begin
                    cfg_val[CFG_PULSE_MIN] = pick_reg(500000, 2500000, PULSE_W);
                    cfg_val[CFG_PULSE_MAX] = pick_reg(500000, 2500000, PULSE_W);
                    cfg_val[CFG_RATED_MIN] = pick_reg(0, 359, DEG_W);
                    cfg_val[CFG_RATED_MAX] = pick_reg(1, 360, DEG_W);
                    cfg_val[CFG_UPPER]     = pick_reg(0, 23040, ANG_W);
                    cfg_val[CFG_LOWER]     = pick_reg(0, 23040, ANG_W);
                    cfg_val[CFG_OFFSET]    = pick_reg(0, 23040, ANG_W);
                    with_offset = $urandom_range(1);
                end
            endcase
            apply_settings(with_offset);
            set_idling(idle_mode_t'(ph % 4));
            // back up the block: receiver holds off while commands keep coming
            if (ph % 4 == 0)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_random_cmd();
        end
        drain();

        $display("Covered %0d commands over %0d register settings, %0d results checked",
                 items_sent, LAST_PHASE + 1, sb.results_checked);
        $display("Idling: none, sender, receiver and both; output held off %0d cycles",
                 HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
src/sau_pkg.sv
src/sau_div.sv
src/servo_angle_pulse_unit_top.sv
dv/tb_top.sv
